// ===== rtl/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd_pkg
// Types, constants and bit helpers for the addressable led pulse driver.
// ----------------------------------------------------------------------------
package lpd_pkg;

    localparam int MAX_LEDS = 128;
    localparam int LED_AW   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CNT_W    = ($clog2(MAX_LEDS + 1) > 8) ? $clog2(MAX_LEDS + 1) : 8;
    localparam int COLOR_W  = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_ORDER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEDS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS   = 3'd4;

    // byte order codes, anything else sends grb
    localparam logic [1:0] ORDER_GRB = 2'd0;
    localparam logic [1:0] ORDER_RGB = 2'd1;
    localparam logic [1:0] ORDER_BGR = 2'd2;

    localparam logic [1:0]  BYTE_ORDER_RST  = ORDER_GRB;
    localparam logic [7:0]  ACTIVE_LEDS_RST = 8'd67;
    localparam logic [7:0]  SHORT_TICKS_RST = 8'd14;
    localparam logic [7:0]  LONG_TICKS_RST  = 8'd38;
    localparam logic [15:0] GAP_TICKS_RST   = 16'd14400;

    typedef enum logic [1:0] {
        MODE_WRITE_ONE = 2'd0,
        MODE_WRITE_ALL = 2'd1,
        MODE_REFRESH   = 2'd2,
        MODE_TICK      = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2,
        PH_GAP  = 2'd3
    } phase_t;

    typedef enum logic {
        CTL_RUN  = 1'b0,
        CTL_FILL = 1'b1
    } ctl_t;

    typedef struct packed {
        logic               we;
        logic [LED_AW-1:0]  wr_addr;
        logic [COLOR_W-1:0] wr_data;
        logic [LED_AW-1:0]  rd_addr;
    } mem_req_t;

    // bit on the wire for a color at a given byte slot and bit position
    function automatic logic pick_bit(
        input logic [COLOR_W-1:0] color,
        input logic [1:0]         order,
        input logic [1:0]         slot,
        input logic [2:0]         bitp
    );
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] s0;
        logic [7:0] s1;
        logic [7:0] s2;
        logic [7:0] sel;
        r = color[23:16];
        g = color[15:8];
        b = color[7:0];
        unique case (order)
            ORDER_RGB:
            begin
                s0 = r; s1 = g; s2 = b;
            end
            ORDER_BGR:
            begin
                s0 = b; s1 = g; s2 = r;
            end
            default:
            begin
                s0 = g; s1 = r; s2 = b;
            end
        endcase
        unique case (slot)
            2'd1:    sel = s1;
            2'd2:    sel = s2;
            default: sel = s0;
        endcase
        return sel[bitp];
    endfunction

    // a zero length pulse counts as one tick
    function automatic logic [15:0] pulse_len(input logic [7:0] v);
        return (v == 8'd0) ? 16'd1 : {8'd0, v};
    endfunction

endpackage

// ===== rtl/lpd_in_if.sv =====
// ----------------------------------------------------------------------------
// lpd_in_if
// Command channel: mode, led index and color, valid/ready.
// ----------------------------------------------------------------------------
interface lpd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [6:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, mode, led_index, red, green, blue, input ready);
    modport sink   (input valid, mode, led_index, red, green, blue, output ready);
endinterface

// ===== rtl/lpd_out_if.sv =====
// ----------------------------------------------------------------------------
// lpd_out_if
// Result channel: line level and busy flag, valid/ready.
// ----------------------------------------------------------------------------
interface lpd_out_if;
    logic valid;
    logic ready;
    logic data_line;
    logic busy_res;

    modport source (output valid, data_line, busy_res, input ready);
    modport sink   (input valid, data_line, busy_res, output ready);
endinterface

// ===== rtl/lpd_store.sv =====
// ----------------------------------------------------------------------------
// lpd_store
// Color store: one write port, one registered read port, per-entry valid
// bits so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module lpd_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpd_pkg::mem_req_t             req,
    output logic [lpd_pkg::COLOR_W-1:0]   rd_data
);
    import lpd_pkg::*;

    logic [COLOR_W-1:0] mem [MAX_LEDS];
    logic [MAX_LEDS-1:0] vld_reg;
    logic [COLOR_W-1:0] rd_data_reg;
    logic               rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[req.rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/addressable_led_pulse_driver.sv =====
// ----------------------------------------------------------------------------
// addressable_led_pulse_driver
// One-wire serial led driver: color store in memory, refresh sequencer with
// pulse timing driven by tick commands.
// ----------------------------------------------------------------------------
//  channel   dir   beat contents
//  item      in    mode, led_index, red, green, blue
//  result    out   data_line, busy_res
//  cfg       in    cfg_we, cfg_index, cfg_data (write only)
//
// items are taken while the result slot is free; write-all writes one store
// entry per cycle via the single memory write port, the last until out_free.
// the store reads as zero after reset through per-entry valid bits, no sweep.
// the next led's color is fetched from the store behind the current one, so
// a refresh never waits on the memory; entry 0 is mirrored for refresh start.
// a stalled result holds the item channel off until it is taken.
module addressable_led_pulse_driver (
    input  logic                              clk,
    input  logic                              rst_n,
    lpd_in_if.sink                            item,
    lpd_out_if.source                         result,
    input  logic                              cfg_we,
    input  logic [lpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lpd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lpd_pkg::*;

    // configuration
    logic [1:0]  byte_order_reg;
    logic [7:0]  active_leds_reg;
    logic [7:0]  short_ticks_reg;
    logic [7:0]  long_ticks_reg;
    logic [15:0] gap_ticks_reg;

    // sequencer state
    ctl_t               ctl_reg, ctl_next;
    phase_t             phase_reg, phase_next;
    logic [15:0]        tc_reg, tc_next;
    logic [LED_AW-1:0]  led_ptr_reg, led_ptr_next;
    logic [1:0]         slot_reg, slot_next;
    logic [2:0]         bit_reg, bit_next;
    logic [COLOR_W-1:0] cur_color_reg, cur_color_next;
    logic [COLOR_W-1:0] next_color_reg;
    logic [COLOR_W-1:0] head_color_reg, head_color_next;
    logic [LED_AW-1:0]  fill_idx_reg, fill_idx_next;
    logic [COLOR_W-1:0] fill_color_reg, fill_color_next;

    logic res_valid_reg, res_valid_next;
    logic res_line_reg, res_line_next;
    logic res_busy_reg, res_busy_next;

    mem_req_t           mem_req;
    logic [COLOR_W-1:0] mem_rd_data;

    logic               out_free;
    logic               accept;
    logic               load;
    logic               idle;
    mode_t              mode;
    logic [COLOR_W-1:0] in_color;
    logic [CNT_W-1:0]   led_n;
    logic               last_led;
    logic               fill_last;
    logic               idx_ok;
    logic [15:0]        tc_dec;
    logic               cur_bit;
    logic [15:0]        lo_tc;
    logic [COLOR_W-1:0] nb_color;
    logic [1:0]         nb_slot;
    logic [2:0]         nb_bit;
    logic [15:0]        nb_tc;
    logic [15:0]        head_tc;

    lpd_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_order_reg  <= BYTE_ORDER_RST;
            active_leds_reg <= ACTIVE_LEDS_RST;
            short_ticks_reg <= SHORT_TICKS_RST;
            long_ticks_reg  <= LONG_TICKS_RST;
            gap_ticks_reg   <= GAP_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BYTE_ORDER:  byte_order_reg  <= cfg_data[1:0];
                CFG_ACTIVE_LEDS: active_leds_reg <= cfg_data[7:0];
                CFG_SHORT_TICKS: short_ticks_reg <= cfg_data[7:0];
                CFG_LONG_TICKS:  long_ticks_reg  <= cfg_data[7:0];
                CFG_GAP_TICKS:   gap_ticks_reg   <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    assign out_free = !res_valid_reg || result.ready;
    assign item.ready = (ctl_reg == CTL_RUN) && out_free;
    assign accept = item.valid && item.ready;
    assign mode = mode_t'(item.mode);
    assign in_color = {item.red, item.green, item.blue};
    assign idle = (phase_reg == PH_IDLE);

    assign led_n = (CNT_W'(active_leds_reg) > CNT_W'(MAX_LEDS)) ?
                   CNT_W'(MAX_LEDS) : CNT_W'(active_leds_reg);
    assign last_led  = (CNT_W'(led_ptr_reg) + CNT_W'(1)) >= led_n;
    assign fill_last = (CNT_W'(fill_idx_reg) + CNT_W'(1)) == led_n;
    assign idx_ok    = CNT_W'(item.led_index) < CNT_W'(MAX_LEDS);

    assign tc_dec = (tc_reg != 16'd0) ? tc_reg - 16'd1 : 16'd0;

    // timing of the low phase of the bit on the wire now
    assign cur_bit = pick_bit(cur_color_reg, byte_order_reg, slot_reg, bit_reg);
    assign lo_tc   = pulse_len(cur_bit ? short_ticks_reg : long_ticks_reg);

    // position of the following bit, crossing into the prefetched led
    always_comb
    begin
        if (bit_reg != 3'd0)
        begin
            nb_color = cur_color_reg;
            nb_slot  = slot_reg;
            nb_bit   = bit_reg - 3'd1;
        end
        else if (slot_reg < 2'd2)
        begin
            nb_color = cur_color_reg;
            nb_slot  = slot_reg + 2'd1;
            nb_bit   = 3'd7;
        end
        else
        begin
            nb_color = next_color_reg;
            nb_slot  = 2'd0;
            nb_bit   = 3'd7;
        end
    end

    assign nb_tc = pulse_len(pick_bit(nb_color, byte_order_reg, nb_slot, nb_bit) ?
                             long_ticks_reg : short_ticks_reg);
    assign head_tc = pulse_len(pick_bit(head_color_reg, byte_order_reg, 2'd0, 3'd7) ?
                               long_ticks_reg : short_ticks_reg);

    always_comb
    begin
        ctl_next        = ctl_reg;
        phase_next      = phase_reg;
        tc_next         = tc_reg;
        led_ptr_next    = led_ptr_reg;
        slot_next       = slot_reg;
        bit_next        = bit_reg;
        cur_color_next  = cur_color_reg;
        head_color_next = head_color_reg;
        fill_idx_next   = fill_idx_reg;
        fill_color_next = fill_color_reg;
        load            = 1'b0;

        mem_req.we      = 1'b0;
        mem_req.wr_addr = fill_idx_reg;
        mem_req.wr_data = fill_color_reg;
        // always fetch the led after the current one
        mem_req.rd_addr = led_ptr_reg + LED_AW'(1);

        unique case (ctl_reg)
            CTL_RUN:
            begin
                if (accept)
                begin
                    load = 1'b1;
                    unique case (mode)
                        MODE_WRITE_ONE:
                        begin
                            if (idle && idx_ok)
                            begin
                                mem_req.we      = 1'b1;
                                mem_req.wr_addr = LED_AW'(item.led_index);
                                mem_req.wr_data = in_color;
                                if (LED_AW'(item.led_index) == '0)
                                begin
                                    head_color_next = in_color;
                                end
                            end
                        end
                        MODE_WRITE_ALL:
                        begin
                            if (idle && (led_n != '0))
                            begin
                                load            = 1'b0;
                                ctl_next        = CTL_FILL;
                                fill_idx_next   = '0;
                                fill_color_next = in_color;
                                head_color_next = in_color;
                            end
                        end
                        MODE_REFRESH:
                        begin
                            if (idle)
                            begin
                                led_ptr_next = '0;
                                slot_next    = 2'd0;
                                bit_next     = 3'd7;
                                if (led_n == '0)
                                begin
                                    phase_next = (gap_ticks_reg == 16'd0) ? PH_IDLE : PH_GAP;
                                    tc_next    = gap_ticks_reg;
                                end
                                else
                                begin
                                    phase_next     = PH_HIGH;
                                    cur_color_next = head_color_reg;
                                    tc_next        = head_tc;
                                end
                            end
                        end
                        MODE_TICK:
                        begin
                            if (!idle)
                            begin
                                tc_next = tc_dec;
                                if (tc_dec == 16'd0)
                                begin
                                    unique case (phase_reg)
                                        PH_HIGH:
                                        begin
                                            phase_next = PH_LOW;
                                            tc_next    = lo_tc;
                                        end
                                        PH_LOW:
                                        begin
                                            if (bit_reg == 3'd0 && slot_reg >= 2'd2 && last_led)
                                            begin
                                                led_ptr_next = '0;
                                                slot_next    = 2'd0;
                                                bit_next     = 3'd7;
                                                phase_next   = (gap_ticks_reg == 16'd0) ?
                                                               PH_IDLE : PH_GAP;
                                                tc_next      = gap_ticks_reg;
                                            end
                                            else
                                            begin
                                                if (bit_reg == 3'd0 && slot_reg >= 2'd2)
                                                begin
                                                    led_ptr_next = led_ptr_reg + LED_AW'(1);
                                                end
                                                cur_color_next = nb_color;
                                                slot_next      = nb_slot;
                                                bit_next       = nb_bit;
                                                phase_next     = PH_HIGH;
                                                tc_next        = nb_tc;
                                            end
                                        end
                                        PH_GAP:
                                        begin
                                            phase_next = PH_IDLE;
                                        end
                                        default: ;
                                    endcase
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            CTL_FILL:
            begin
                mem_req.we = 1'b1;
                if (fill_last)
                begin
                    // last entry is rewritten until the result slot frees up
                    if (out_free)
                    begin
                        load     = 1'b1;
                        ctl_next = CTL_RUN;
                    end
                end
                else
                begin
                    fill_idx_next = fill_idx_reg + LED_AW'(1);
                end
            end
            default: ;
        endcase

        res_valid_next = load ? 1'b1 : (result.ready ? 1'b0 : res_valid_reg);
        res_line_next  = load ? (phase_next == PH_HIGH) : res_line_reg;
        res_busy_next  = load ? (phase_next != PH_IDLE) : res_busy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg        <= CTL_RUN;
            phase_reg      <= PH_IDLE;
            tc_reg         <= 16'd0;
            led_ptr_reg    <= '0;
            slot_reg       <= 2'd0;
            bit_reg        <= 3'd7;
            head_color_reg <= '0;
            fill_idx_reg   <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            ctl_reg        <= ctl_next;
            phase_reg      <= phase_next;
            tc_reg         <= tc_next;
            led_ptr_reg    <= led_ptr_next;
            slot_reg       <= slot_next;
            bit_reg        <= bit_next;
            head_color_reg <= head_color_next;
            fill_idx_reg   <= fill_idx_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_color_reg  <= cur_color_next;
        next_color_reg <= mem_rd_data;
        fill_color_reg <= fill_color_next;
        res_line_reg   <= res_line_next;
        res_busy_reg   <= res_busy_next;
    end

    assign result.valid     = res_valid_reg;
    assign result.data_line = res_line_reg;
    assign result.busy_res  = res_busy_reg;

`ifndef SYNTHESIS
    a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (phase_reg == PH_IDLE))
        else $error("store written during a refresh");

    a_pulse_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HIGH || phase_reg == PH_LOW) |-> (tc_reg != 16'd0))
        else $error("pulse phase with empty tick count");

    a_led_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HIGH || phase_reg == PH_LOW) |->
        (CNT_W'(led_ptr_reg) < led_n))
        else $error("led pointer past active count");

    a_single_cycle_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode != MODE_WRITE_ALL) |=> res_valid_reg)
        else $error("result missing after single cycle beat");
`endif

endmodule
